// File: src/fmp_pkg.sv
// Shared types and constants for the fixed-point Mandelbrot pixel block.
// No dependencies; every other file imports this package.
`default_nettype none

package fmp_pkg;

  localparam int FX_W      = 64;   // fixed-point word
  localparam int CFG_IDX_W = 3;
  localparam int ARGB_W    = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_REAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IMAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H     = 3'd5;

  localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;
  localparam logic [ARGB_W-1:0] ARGB_BLACK   = 32'hFF00_0000;

  // controller -> datapath
  typedef struct packed {
    logic latch_px;   // capture the pixel coordinate
    logic start_a;    // multiply half-width, half-height, x by scale
    logic cap_a;      // form real part of c and y origin
    logic start_b;    // multiply y by scale
    logic cap_b;      // form imaginary part of c, clear z
    logic start_it;   // z squared products
    logic advance;    // write back z, bump count
    logic load_out;   // fill output register
  } fmp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mul_done;
    logic lim_hit;
    logic escape;
  } fmp_sts_t;

endpackage

`default_nettype wire

// File: src/fmp_if.sv
// Channel interfaces: pixel input, colour result and configuration write.
// Uses fmp_pkg for the fixed widths.
`default_nettype none

interface fmp_pix_if #(parameter int COORD_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface fmp_res_if import fmp_pkg::*; #(parameter int ITER_BITS = 13) ();
  logic                 valid;
  logic                 ready;
  logic [ARGB_W-1:0]    argb_colour;
  logic [ITER_BITS-1:0] iteration_count;
  logic                 inside_set;
  modport source (output valid, argb_colour, iteration_count, inside_set, input ready);
  modport sink   (input valid, argb_colour, iteration_count, inside_set, output ready);
endinterface

interface fmp_cfg_if import fmp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FX_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/fixed_point_mandelbrot_pixel_top.sv
// Top level of the fixed-point Mandelbrot escape-time pixel block.
// Depends on fmp_pkg, fmp_if, fmp_regs, fmp_ctrl, fmp_dp, fmp_mul.
//
//   channel   dir  handshake           payload
//   in_pix    in   valid/ready         pixel_x, pixel_y
//   out_res   out  valid/ready         argb_colour, iteration_count, inside_set
//   cfg_wr    in   valid/ready (=1)    index, data
//
// One pixel at a time: from transfer in to result valid it runs the setup multiplies and p product passes
// (p = the iteration count, plus one more when the point escapes).
// Each iteration is one pass of three shared 33x33 multiplier units, four partial products each.
// Synchronous active-low reset returns registers to the default view (center -0.5, 256 iterations).
// A finished result waits in the output register; the next pixel is taken meanwhile.
// A stalled output holds the block in its final state only when a second result is ready.
`default_nettype none

module fixed_point_mandelbrot_pixel_top import fmp_pkg::*; #(
  parameter int FRAC_BITS  = 36,
  parameter int COORD_BITS = 12,
  parameter int ITER_BITS  = 13
) (
  input  logic       clk,
  input  logic       rst_n,
  fmp_pix_if.sink    in_pix,
  fmp_res_if.source  out_res,
  fmp_cfg_if.sink    cfg_wr
);

  logic [FX_W-1:0]      center_real, center_imag;
  logic [FX_W-2:0]      pixel_scale;
  logic [ITER_BITS-1:0] iter_limit;
  logic [COORD_BITS:0]  frame_w, frame_h;
  fmp_cmd_t             cmd;
  fmp_sts_t             sts;
  logic                 in_ready, out_valid;

  fmp_regs #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_wr),
    .center_real (center_real),
    .center_imag (center_imag),
    .pixel_scale (pixel_scale),
    .iter_limit  (iter_limit),
    .frame_w     (frame_w),
    .frame_h     (frame_h)
  );

  fmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fmp_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .center_real     (center_real),
    .center_imag     (center_imag),
    .pixel_scale     (pixel_scale),
    .iter_limit      (iter_limit),
    .frame_w         (frame_w),
    .frame_h         (frame_h),
    .pixel_x         (in_pix.pixel_x),
    .pixel_y         (in_pix.pixel_y),
    .argb_colour     (out_res.argb_colour),
    .iteration_count (out_res.iteration_count),
    .inside_set      (out_res.inside_set)
  );

  assign in_pix.ready  = in_ready;
  assign out_res.valid = out_valid;

endmodule

`default_nettype wire

// File: src/fmp_mul.sv
// Sequential signed 64x64 fixed-point multiplier: four 33x33 partial products.
// Depends on fmp_pkg. Result is the product shifted right by FRAC_BITS, 64-bit wrap.
`default_nettype none

module fmp_mul import fmp_pkg::*; #(
  parameter int FRAC_BITS = 36
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [FX_W-1:0] a,
  input  logic [FX_W-1:0] b,
  output logic [FX_W-1:0] p,
  output logic            done
);

  localparam int HALF = FX_W / 2;
  localparam int ACC_W = 2 * FX_W;

  logic [FX_W-1:0]         a_r, b_r;
  logic                    issue_r, acc_vld_r, last_r, done_r;
  logic [1:0]              step_r, sh_r;
  logic signed [2*HALF+1:0] prod_r;
  logic [ACC_W-1:0]        acc_r;

  logic signed [HALF:0]     xa, xb;
  logic signed [2*HALF+1:0] prod_nxt;
  logic [1:0]               sh_nxt;
  logic [ACC_W-1:0]         pp_ext, acc_nxt;

  // high halves carry the sign, low halves are unsigned
  assign xa = step_r[1] ? {a_r[FX_W-1], a_r[FX_W-1:HALF]} : {1'b0, a_r[HALF-1:0]};
  assign xb = step_r[0] ? {b_r[FX_W-1], b_r[FX_W-1:HALF]} : {1'b0, b_r[HALF-1:0]};
  assign prod_nxt = xa * xb;
  assign sh_nxt   = {1'b0, step_r[1]} + {1'b0, step_r[0]};

  assign pp_ext  = {{(ACC_W-2*HALF-2){prod_r[2*HALF+1]}}, prod_r} << {sh_r, 5'b0};
  assign acc_nxt = acc_r + pp_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r   <= 1'b0;
      step_r    <= 2'd0;
      acc_vld_r <= 1'b0;
      last_r    <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      if (start) begin
        issue_r <= 1'b1;
        step_r  <= 2'd0;
      end else if (issue_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) issue_r <= 1'b0;
      end
      acc_vld_r <= issue_r && !start;
      last_r    <= issue_r && !start && (step_r == 2'd3);
      if (start) done_r <= 1'b0;
      else if (acc_vld_r && last_r) done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (issue_r) begin
      prod_r <= prod_nxt;
      sh_r   <= sh_nxt;
    end
    if (start) acc_r <= '0;
    else if (acc_vld_r) acc_r <= acc_nxt;
  end

  assign p    = acc_r[FRAC_BITS +: FX_W];
  assign done = done_r;

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && start |=> issue_r && !done_r)
    else $error("multiplier did not begin after start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !issue_r && !acc_vld_r)
    else $error("multiplier done while partial products pending");

endmodule

`default_nettype wire

// File: src/fmp_dp.sv
// Datapath: pixel-to-c mapping, z iteration, palette tracking, output register.
// Depends on fmp_pkg and fmp_mul (three instances).
`default_nettype none

module fmp_dp import fmp_pkg::*; #(
  parameter int FRAC_BITS  = 36,
  parameter int COORD_BITS = 12,
  parameter int ITER_BITS  = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fmp_cmd_t              cmd,
  output fmp_sts_t              sts,
  input  logic [FX_W-1:0]       center_real,
  input  logic [FX_W-1:0]       center_imag,
  input  logic [FX_W-2:0]       pixel_scale,
  input  logic [ITER_BITS-1:0]  iter_limit,
  input  logic [COORD_BITS:0]   frame_w,
  input  logic [COORD_BITS:0]   frame_h,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  output logic [ARGB_W-1:0]     argb_colour,
  output logic [ITER_BITS-1:0]  iteration_count,
  output logic                  inside_set
);

  localparam logic [FX_W-1:0] BAILOUT  = 64'd4 << FRAC_BITS;
  localparam logic [8:0]      PAL_STEP = 9'd7;

  localparam logic [2:0] PH_RED_GUP = 3'd0;
  localparam logic [2:0] PH_GRN_RDN = 3'd1;
  localparam logic [2:0] PH_GRN_BUP = 3'd2;
  localparam logic [2:0] PH_BLU_GDN = 3'd3;
  localparam logic [2:0] PH_BLU_RUP = 3'd4;
  localparam logic [2:0] PH_RED_BDN = 3'd5;

  logic [COORD_BITS-1:0] px_r, py_r;
  logic [FX_W-1:0]       cr_r, ci_r, ymin_r, zr_r, zi_r;
  logic [ITER_BITS-1:0]  count_r;
  logic [7:0]            t_r;
  logic [2:0]            phase_r;
  logic [ARGB_W-1:0]     argb_r;
  logic [ITER_BITS-1:0]  cnt_out_r;
  logic                  inside_r;

  logic [FX_W-1:0] mul_a [3];
  logic [FX_W-1:0] mul_b [3];
  logic [FX_W-1:0] mul_p [3];
  logic [2:0]      mul_start, mul_done;

  logic [FX_W-1:0] scale_fx, hw_fx, hh_fx, px_fx, py_fx, mag2;
  logic [8:0]      t_sum;
  logic [7:0]      red, grn, blu;

  assign scale_fx = {1'b0, pixel_scale};
  assign hw_fx    = FX_W'(frame_w[COORD_BITS:1]) << FRAC_BITS;
  assign hh_fx    = FX_W'(frame_h[COORD_BITS:1]) << FRAC_BITS;
  assign px_fx    = FX_W'(px_r) << FRAC_BITS;
  assign py_fx    = FX_W'(py_r) << FRAC_BITS;

  // unit 0: zr*zr, unit 1: zi*zi, unit 2: zr*zi during iteration
  always_comb begin
    mul_a[0] = zr_r;
    mul_b[0] = zr_r;
    mul_a[1] = zi_r;
    mul_b[1] = zi_r;
    mul_a[2] = zr_r;
    mul_b[2] = zi_r;
    if (cmd.start_a) begin
      mul_a[0] = hw_fx;
      mul_b[0] = scale_fx;
      mul_a[1] = hh_fx;
      mul_b[1] = scale_fx;
      mul_a[2] = px_fx;
      mul_b[2] = scale_fx;
    end else if (cmd.start_b) begin
      mul_a[0] = py_fx;
      mul_b[0] = scale_fx;
    end
  end

  assign mul_start[0] = cmd.start_a || cmd.start_b || cmd.start_it;
  assign mul_start[1] = cmd.start_a || cmd.start_it;
  assign mul_start[2] = cmd.start_a || cmd.start_it;

  for (genvar g = 0; g < 3; g++) begin : g_mul
    fmp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk   (clk),
      .rst_n (rst_n),
      .start (mul_start[g]),
      .a     (mul_a[g]),
      .b     (mul_b[g]),
      .p     (mul_p[g]),
      .done  (mul_done[g])
    );
  end

  assign mag2  = mul_p[0] + mul_p[1];
  assign t_sum = {1'b0, t_r} + PAL_STEP;

  assign sts.mul_done = mul_done[0];
  assign sts.lim_hit  = (count_r >= iter_limit);
  assign sts.escape   = ($signed(mag2) > $signed(BAILOUT));

  always_comb begin
    case (phase_r)
      PH_RED_GUP: begin red = 8'd255;       grn = t_r;          blu = 8'd0;         end
      PH_GRN_RDN: begin red = 8'd255 - t_r; grn = 8'd255;       blu = 8'd0;         end
      PH_GRN_BUP: begin red = 8'd0;         grn = 8'd255;       blu = t_r;          end
      PH_BLU_GDN: begin red = 8'd0;         grn = 8'd255 - t_r; blu = 8'd255;       end
      PH_BLU_RUP: begin red = t_r;          grn = 8'd0;         blu = 8'd255;       end
      PH_RED_BDN: begin red = 8'd255;       grn = 8'd0;         blu = 8'd255 - t_r; end
      default:    begin red = 8'd0;         grn = 8'd0;         blu = 8'd0;         end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_px) begin
      px_r <= pixel_x;
      py_r <= pixel_y;
    end
    if (cmd.cap_a) begin
      cr_r   <= center_real - mul_p[0] + mul_p[2];
      ymin_r <= center_imag - mul_p[1];
    end
    if (cmd.cap_b) begin
      ci_r    <= ymin_r + mul_p[0];
      zr_r    <= '0;
      zi_r    <= '0;
      count_r <= '0;
      t_r     <= '0;
      phase_r <= PH_RED_GUP;
    end else if (cmd.advance) begin
      zr_r    <= mul_p[0] - mul_p[1] + cr_r;
      zi_r    <= {mul_p[2][FX_W-2:0], 1'b0} + ci_r;
      count_r <= count_r + ITER_BITS'(1);
      // count*7 climbs by less than 256, so the phase moves at most one step
      t_r     <= t_sum[7:0];
      if (t_sum[8]) phase_r <= (phase_r == PH_RED_BDN) ? PH_RED_GUP : phase_r + 3'd1;
    end
    if (cmd.load_out) begin
      argb_r    <= sts.lim_hit ? ARGB_BLACK : {ALPHA_OPAQUE, red, grn, blu};
      cnt_out_r <= count_r;
      inside_r  <= sts.lim_hit;
    end
  end

  assign argb_colour     = argb_r;
  assign iteration_count = cnt_out_r;
  assign inside_set      = inside_r;

  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done[0] |-> mul_done[1] && mul_done[2])
    else $error("multiplier units out of step");

endmodule

`default_nettype wire

// File: src/fmp_regs.sv
// Configuration register file: view center, scale, iteration limit, frame size.
// Depends on fmp_pkg and fmp_cfg_if.
`default_nettype none

module fmp_regs import fmp_pkg::*; #(
  parameter int FRAC_BITS  = 36,
  parameter int COORD_BITS = 12,
  parameter int ITER_BITS  = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fmp_cfg_if.sink               cfg,
  output logic [FX_W-1:0]       center_real,
  output logic [FX_W-1:0]       center_imag,
  output logic [FX_W-2:0]       pixel_scale,
  output logic [ITER_BITS-1:0]  iter_limit,
  output logic [COORD_BITS:0]   frame_w,
  output logic [COORD_BITS:0]   frame_h
);

  // -0.5 and 3/400 in fixed point
  localparam logic [FX_W-1:0] CRE_RST   = ~((64'd1 << (FRAC_BITS - 1)) - 64'd1);
  localparam logic [FX_W-1:0] SCALE_RST = (64'd3 << FRAC_BITS) / 400;

  logic [FX_W-1:0]       cre_r, cim_r;
  logic [FX_W-2:0]       scale_r;
  logic [ITER_BITS-1:0]  limit_r;
  logic [COORD_BITS:0]   fw_r, fh_r;
  logic                  wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cre_r   <= CRE_RST;
      cim_r   <= '0;
      scale_r <= SCALE_RST[FX_W-2:0];
      limit_r <= ITER_BITS'(256);
      fw_r    <= (COORD_BITS+1)'(400);
      fh_r    <= (COORD_BITS+1)'(368);
    end else if (wr) begin
      case (cfg.index)
        REG_CENTER_REAL: cre_r   <= cfg.data;
        REG_CENTER_IMAG: cim_r   <= cfg.data;
        REG_PIXEL_SCALE: scale_r <= cfg.data[FX_W-2:0];
        REG_ITER_LIMIT:  limit_r <= cfg.data[ITER_BITS-1:0];
        REG_FRAME_W:     fw_r    <= cfg.data[COORD_BITS:0];
        REG_FRAME_H:     fh_r    <= cfg.data[COORD_BITS:0];
        default: ;
      endcase
    end
  end

  assign center_real = cre_r;
  assign center_imag = cim_r;
  assign pixel_scale = scale_r;
  assign iter_limit  = limit_r;
  assign frame_w     = fw_r;
  assign frame_h     = fh_r;

endmodule

`default_nettype wire

// File: src/fmp_ctrl.sv
// Controller FSM: sequences the setup multiplies, iteration loop and output load.
// Depends on fmp_pkg (command and status structs).
`default_nettype none

module fmp_ctrl import fmp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  fmp_sts_t sts,
  output fmp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SET_A  = 3'd1;
  localparam logic [2:0] ST_WAIT_A = 3'd2;
  localparam logic [2:0] ST_SET_B  = 3'd3;
  localparam logic [2:0] ST_WAIT_B = 3'd4;
  localparam logic [2:0] ST_ITER   = 3'd5;
  localparam logic [2:0] ST_WAIT_I = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.latch_px = in_valid;
        if (in_valid) state_nxt = ST_SET_A;
      end
      ST_SET_A: begin
        cmd.start_a = 1'b1;
        state_nxt   = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (sts.mul_done) begin
          cmd.cap_a = 1'b1;
          state_nxt = ST_SET_B;
        end
      end
      ST_SET_B: begin
        cmd.start_b = 1'b1;
        state_nxt   = ST_WAIT_B;
      end
      ST_WAIT_B: begin
        if (sts.mul_done) begin
          cmd.cap_b = 1'b1;
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        if (sts.lim_hit) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.start_it = 1'b1;
          state_nxt    = ST_WAIT_I;
        end
      end
      ST_WAIT_I: begin
        if (sts.mul_done) begin
          if (sts.escape) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = ST_ITER;
          end
        end
      end
      ST_FINISH: begin
        // output register free, or its result leaves this cycle
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> state_r == ST_SET_A)
    else $error("transfer in did not start setup");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cmd.load_out |=> out_valid_r)
    else $error("output load lost");

  a_wait_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && state_r == ST_WAIT_I && !sts.mul_done |=> state_r == ST_WAIT_I)
    else $error("left iteration wait before products ready");

endmodule

`default_nettype wire
